// ===== rtl/core/kmp_pkg.sv =====
// kmp_pkg: shared types and constants for the streaming kmp matcher
// command codes and the controller/datapath command and status structs
// no dependencies
package kmp_pkg;

  localparam int CMD_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int MATCH_E_W = 32;

  // input command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_TEXT   = 2'd2,
    CMD_EOT    = 2'd3
  } kmp_cmd_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // latch the beat and issue the first table read
    logic advance;  // follow the failure link and read again
    logic finish;   // commit state and load the result register
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_read;     // beat on the input needs a table walk
    logic keep_seeking;  // mismatch with a non-zero prefix
    logic out_free;      // result register can take a new beat
  } dp_status_t;

endpackage

// ===== rtl/core/kmp_ram.sv =====
// kmp_ram: generic single write, single read port ram with registered read
// read data holds while read enable is low; depends on nothing
module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/kmp_datapath.sv =====
// kmp_datapath: pattern and failure rams, match state and result register
// depends on kmp_pkg and kmp_ram; driven by kmp_ctrl
module kmp_datapath #(
  parameter int PATTERN_MAX = 64,
  parameter int INDEX_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  kmp_pkg::dp_cmd_t                  cmd,
  output kmp_pkg::dp_status_t               status,
  input  logic [kmp_pkg::CMD_W-1:0]         in_command,
  input  logic [kmp_pkg::CHAR_W-1:0]        in_char_value,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic                              out_match_here,
  output logic                              out_found,
  output logic [kmp_pkg::MATCH_E_W-1:0]     out_match_end,
  output logic [$clog2(PATTERN_MAX+1)-1:0]  out_matched_length,
  output logic                              out_overflow
);

  localparam int AW = $clog2(PATTERN_MAX);
  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int EW = (INDEX_BITS < kmp_pkg::MATCH_E_W) ? INDEX_BITS : kmp_pkg::MATCH_E_W;

  // latched beat and walk pointer
  kmp_pkg::kmp_cmd_t          cmd_r;
  logic [kmp_pkg::CHAR_W-1:0] char_r;
  logic [AW-1:0]              k_r, k_nxt;

  // match state
  logic [LW-1:0]         len_r, len_nxt;
  logic [AW-1:0]         bp_r, bp_nxt;
  logic [AW-1:0]         mp_r, mp_nxt;
  logic                  found_r, found_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic                  ovf_r, ovf_nxt;

  // result register
  logic                          out_valid_r, out_valid_nxt;
  logic                          here_r, here_nxt;
  logic                          ofound_r, ofound_nxt;
  logic [kmp_pkg::MATCH_E_W-1:0] end_r, end_nxt;
  logic [LW-1:0]                 mlen_r, mlen_nxt;
  logic                          oovf_r, oovf_nxt;

  // ram ports
  logic                       rd_en;
  logic [AW-1:0]              rd_k;
  logic [kmp_pkg::CHAR_W-1:0] pat_rd;
  logic [AW-1:0]              fail_rd;
  logic                       wr_en;
  logic [AW-1:0]              wr_fail;

  kmp_pkg::kmp_cmd_t in_cmd;
  logic              len_nz, len_room, hit;
  logic [LW-1:0]     k_fin;

  assign in_cmd   = kmp_pkg::kmp_cmd_t'(in_command);
  assign len_nz   = (len_r != '0);
  assign len_room = (len_r < LW'(PATTERN_MAX));
  assign hit      = (pat_rd == char_r);
  assign k_fin    = LW'(k_r) + LW'(hit);

  // status towards the controller
  always_comb begin
    status.need_read = 1'b0;
    case (in_cmd)
      kmp_pkg::CMD_APPEND: status.need_read = len_nz && len_room;
      kmp_pkg::CMD_TEXT:   status.need_read = len_nz;
      default:             status.need_read = 1'b0;
    endcase
    status.keep_seeking = (k_r != '0) && !hit;
    status.out_free     = !out_valid_r || !out_stall;
  end

  // walk pointer: start from the build prefix or the match position
  always_comb begin
    k_nxt = k_r;
    if (cmd.load) begin
      k_nxt = (in_cmd == kmp_pkg::CMD_APPEND) ? bp_r : mp_r;
    end else if (cmd.advance) begin
      k_nxt = fail_rd;
    end
  end

  assign rd_en = cmd.load || cmd.advance;
  assign rd_k  = k_nxt;

  kmp_ram #(
    .WIDTH(kmp_pkg::CHAR_W),
    .DEPTH(PATTERN_MAX)
  ) u_pat_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(len_r[AW-1:0]),
    .wr_data(char_r),
    .rd_en  (rd_en),
    .rd_addr(rd_k),
    .rd_data(pat_rd)
  );

  kmp_ram #(
    .WIDTH(AW),
    .DEPTH(PATTERN_MAX)
  ) u_fail_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(len_r[AW-1:0]),
    .wr_data(wr_fail),
    .rd_en  (rd_en),
    .rd_addr(rd_k - AW'(1)),
    .rd_data(fail_rd)
  );

  // state update and result on completion of a beat
  always_comb begin
    len_nxt    = len_r;
    bp_nxt     = bp_r;
    mp_nxt     = mp_r;
    found_nxt  = found_r;
    idx_nxt    = idx_r;
    ovf_nxt    = ovf_r;
    wr_en      = 1'b0;
    wr_fail    = '0;
    here_nxt   = here_r;
    ofound_nxt = ofound_r;
    end_nxt    = end_r;
    mlen_nxt   = mlen_r;
    oovf_nxt   = oovf_r;
    if (cmd.finish) begin
      here_nxt   = 1'b0;
      ofound_nxt = found_r;
      end_nxt    = '0;
      mlen_nxt   = '0;
      case (cmd_r)
        kmp_pkg::CMD_CLEAR: begin
          len_nxt    = '0;
          bp_nxt     = '0;
          mp_nxt     = '0;
          found_nxt  = 1'b0;
          idx_nxt    = '0;
          ovf_nxt    = 1'b0;
          ofound_nxt = 1'b0;
        end
        kmp_pkg::CMD_APPEND: begin
          mlen_nxt = LW'(mp_r);
          if (!len_room) begin
            ovf_nxt = 1'b1;
          end else begin
            // first byte has an empty proper prefix
            wr_fail = len_nz ? k_fin[AW-1:0] : '0;
            wr_en   = 1'b1;
            bp_nxt  = wr_fail;
            len_nxt = len_r + LW'(1);
          end
        end
        kmp_pkg::CMD_TEXT: begin
          end_nxt = kmp_pkg::MATCH_E_W'(idx_r[EW-1:0]);
          if (idx_r != {INDEX_BITS{1'b1}}) begin
            idx_nxt = idx_r + INDEX_BITS'(1);
          end
          if (len_nz) begin
            mlen_nxt = k_fin;
            if (k_fin >= len_r) begin
              // full match: fall back to the last byte's failure entry
              here_nxt  = 1'b1;
              found_nxt = 1'b1;
              mp_nxt    = bp_r;
            end else begin
              mp_nxt = k_fin[AW-1:0];
            end
          end
          ofound_nxt = found_nxt;
        end
        kmp_pkg::CMD_EOT: begin
          found_nxt = 1'b0;
          mp_nxt    = '0;
          idx_nxt   = '0;
        end
        default: begin
          ofound_nxt = found_r;
        end
      endcase
      oovf_nxt = ovf_nxt;
    end
  end

  assign out_valid_nxt = cmd.finish ? 1'b1 : (out_valid_r && out_stall);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      bp_r        <= '0;
      mp_r        <= '0;
      found_r     <= 1'b0;
      idx_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      bp_r        <= bp_nxt;
      mp_r        <= mp_nxt;
      found_r     <= found_nxt;
      idx_r       <= idx_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_cmd;
      char_r <= in_char_value;
    end
    k_r      <= k_nxt;
    here_r   <= here_nxt;
    ofound_r <= ofound_nxt;
    end_r    <= end_nxt;
    mlen_r   <= mlen_nxt;
    oovf_r   <= oovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_match_here     = here_r;
  assign out_found          = ofound_r;
  assign out_match_end      = end_r;
  assign out_matched_length = mlen_r;
  assign out_overflow       = oovf_r;

endmodule

// ===== rtl/core/kmp_ctrl.sv =====
// kmp_ctrl: sequencer for one beat at a time through the kmp datapath
// depends on kmp_pkg; drives kmp_datapath through dp_cmd_t
module kmp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  kmp_pkg::dp_status_t status,
  output kmp_pkg::dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   stall_r, stall_nxt;

  // next state and datapath commands
  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    cmd.finish  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = status.need_read ? ST_SEEK : ST_FIN;
        end
      end
      ST_SEEK: begin
        if (status.keep_seeking) begin
          cmd.advance = 1'b1;
        end else if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    stall_nxt = (state_nxt != ST_IDLE);
  end

  // state and registered stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stall_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stall_r <= stall_nxt;
    end
  end

  assign in_stall = stall_r;

endmodule

// ===== rtl/core/kmp_stream_matcher_unit.sv =====
// kmp_stream_matcher_unit: top level of the streaming kmp substring matcher
// depends on kmp_pkg, kmp_ctrl, kmp_datapath and kmp_ram
//
// usage:
//   input channel (in_valid/in_stall) carries a command and a byte: clear,
//   append pattern byte, text byte or end of text. every input beat gives
//   exactly one result beat on the output channel (out_valid/out_stall).
//   timing: a beat is taken, then the pattern and failure rams are read at
//   one address per cycle. clear, end of text, a dropped append, a first
//   pattern byte and a text byte with an empty pattern skip the tables and
//   go straight to their final step. other appends and text bytes walk the
//   tables, with one more read per failure fallback; over a text the
//   fallbacks amortise to under one per byte. the result is registered and
//   appears the cycle after the beat completes.
//   the next input beat is taken while a result waits in the output
//   register; if the receiver stalls, the following beat waits at its final
//   step until the output register frees up, then in_stall holds the input.
//   reset clears the match state, pattern length and flags; pattern
//   contents need no clearing as only written entries are read.
module kmp_stream_matcher_unit #(
  parameter int PATTERN_MAX = 64,
  parameter int INDEX_BITS  = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [kmp_pkg::CMD_W-1:0]         in_command,
  input  logic [kmp_pkg::CHAR_W-1:0]        in_char_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_match_here,
  output logic                              out_found,
  output logic [kmp_pkg::MATCH_E_W-1:0]     out_match_end,
  output logic [$clog2(PATTERN_MAX+1)-1:0]  out_matched_length,
  output logic                              out_overflow
);

  kmp_pkg::dp_cmd_t    dp_cmd;
  kmp_pkg::dp_status_t dp_status;

  // sequencer
  kmp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (dp_status),
    .cmd     (dp_cmd)
  );

  // tables, match state and result register
  kmp_datapath #(
    .PATTERN_MAX(PATTERN_MAX),
    .INDEX_BITS (INDEX_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (dp_cmd),
    .status            (dp_status),
    .in_command        (in_command),
    .in_char_value     (in_char_value),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_match_here    (out_match_here),
    .out_found         (out_found),
    .out_match_end     (out_match_end),
    .out_matched_length(out_matched_length),
    .out_overflow      (out_overflow)
  );

endmodule

// ===== rtl/core/kmp_checker.sv =====
// kmp_checker: port level assertions for kmp_stream_matcher_unit
// depends on kmp_pkg; bound to the top level below
module kmp_checker #(
  parameter int PATTERN_MAX = 64
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [kmp_pkg::CMD_W-1:0]         in_command,
  input logic [kmp_pkg::CHAR_W-1:0]        in_char_value,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_match_here,
  input logic                              out_found,
  input logic [kmp_pkg::MATCH_E_W-1:0]     out_match_end,
  input logic [$clog2(PATTERN_MAX+1)-1:0]  out_matched_length,
  input logic                              out_overflow
);

  // one beat at a time: input is held off right after a beat is taken
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on consecutive cycles");

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_command)
      && $stable(in_char_value))
    else $error("stalled input changed");

  // a match always marks the sticky found flag
  a_match_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match_here |-> out_found)
    else $error("match reported without found");

  // a match covers at least one pattern byte
  a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match_here |-> out_matched_length != '0)
    else $error("match reported with zero length");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match_end)
      && $stable(out_matched_length) && $stable(out_found)
      && $stable(out_match_here) && $stable(out_overflow))
    else $error("stalled result changed");

endmodule

bind kmp_stream_matcher_unit kmp_checker #(
  .PATTERN_MAX(PATTERN_MAX)
) u_kmp_checker (.*);

// ===== bench/kmp_stream_matcher_unit_tb.sv =====
`timescale 1ns / 100ps
// kmp_stream_matcher_unit_tb: self-checking bench for the streaming kmp matcher
// a table of directed beats, then random searches under several idling phases
// depends on kmp_pkg and kmp_stream_matcher_unit
module kmp_stream_matcher_unit_tb;

  localparam int PAT_MAX     = 64;
  localparam int IDX_BITS    = 32;
  localparam int LEN_W       = $clog2(PAT_MAX + 1);
  localparam int RANDOM_BEATS = 1050;
  localparam int PHASE_BEATS = 160;
  localparam int CYCLE_LIMIT = 400000;

  // one result beat as the block reports it
  typedef struct packed {
    logic             match_here;
    logic             found;
    logic [31:0]      match_end;
    logic [LEN_W-1:0] matched_len;
    logic             overflow;
  } match_result_t;

  // one row of the directed table; want is used only where typed is set
  typedef struct packed {
    kmp_pkg::kmp_cmd_t cmd;
    logic [7:0]        ch;
    logic [6:0]        reps;
    logic              typed;
    match_result_t     want;
  } stim_row_t;

  localparam match_result_t RES_ZERO = '0;
  localparam match_result_t RES_IDX1 =
    '{match_here: 1'b0, found: 1'b0, match_end: 32'd1, matched_len: '0, overflow: 1'b0};
  localparam match_result_t RES_FOUND =
    '{match_here: 1'b0, found: 1'b1, match_end: 32'd0, matched_len: '0, overflow: 1'b0};
  localparam match_result_t RES_OVF =
    '{match_here: 1'b0, found: 1'b0, match_end: 32'd0, matched_len: '0, overflow: 1'b1};
  localparam match_result_t RES_FOUND_OVF =
    '{match_here: 1'b0, found: 1'b1, match_end: 32'd0, matched_len: '0, overflow: 1'b1};

  localparam int N_ROWS = 26;
  stim_row_t directed_rows [N_ROWS] = '{
    // after reset, then text with an empty pattern
    '{kmp_pkg::CMD_EOT,    8'h00, 7'd1,  1'b1, RES_ZERO},
    '{kmp_pkg::CMD_TEXT,   8'h00, 7'd1,  1'b1, RES_ZERO},
    '{kmp_pkg::CMD_TEXT,   8'hFF, 7'd1,  1'b1, RES_IDX1},
    '{kmp_pkg::CMD_CLEAR,  8'hFF, 7'd1,  1'b1, RES_ZERO},
    // pattern "aba", overlapping matches in "ababa", then a fallback to zero
    '{kmp_pkg::CMD_APPEND, 8'h61, 7'd1,  1'b1, RES_ZERO},
    '{kmp_pkg::CMD_APPEND, 8'h62, 7'd1,  1'b0, RES_ZERO},
    '{kmp_pkg::CMD_APPEND, 8'h61, 7'd1,  1'b0, RES_ZERO},
    '{kmp_pkg::CMD_TEXT,   8'h61, 7'd1,  1'b0, RES_ZERO},
    '{kmp_pkg::CMD_TEXT,   8'h62, 7'd1,  1'b0, RES_ZERO},
    '{kmp_pkg::CMD_TEXT,   8'h61, 7'd1,  1'b0, RES_ZERO},
    '{kmp_pkg::CMD_TEXT,   8'h62, 7'd1,  1'b0, RES_ZERO},
    '{kmp_pkg::CMD_TEXT,   8'h61, 7'd1,  1'b0, RES_ZERO},
    '{kmp_pkg::CMD_TEXT,   8'h00, 7'd1,  1'b0, RES_ZERO},
    '{kmp_pkg::CMD_EOT,    8'hAA, 7'd1,  1'b1, RES_FOUND},
    '{kmp_pkg::CMD_TEXT,   8'h61, 7'd1,  1'b0, RES_ZERO},
    // extreme byte values in pattern and text
    '{kmp_pkg::CMD_CLEAR,  8'h00, 7'd1,  1'b1, RES_ZERO},
    '{kmp_pkg::CMD_APPEND, 8'hFF, 7'd1,  1'b0, RES_ZERO},
    '{kmp_pkg::CMD_APPEND, 8'h00, 7'd1,  1'b0, RES_ZERO},
    '{kmp_pkg::CMD_TEXT,   8'hFF, 7'd1,  1'b0, RES_ZERO},
    '{kmp_pkg::CMD_TEXT,   8'h00, 7'd1,  1'b0, RES_ZERO},
    // full store, a dropped append, long overlapping run
    '{kmp_pkg::CMD_CLEAR,  8'h00, 7'd1,  1'b1, RES_ZERO},
    '{kmp_pkg::CMD_APPEND, 8'h55, 7'd64, 1'b0, RES_ZERO},
    '{kmp_pkg::CMD_APPEND, 8'hAA, 7'd1,  1'b1, RES_OVF},
    '{kmp_pkg::CMD_TEXT,   8'h55, 7'd70, 1'b0, RES_ZERO},
    '{kmp_pkg::CMD_EOT,    8'h00, 7'd1,  1'b1, RES_FOUND_OVF},
    '{kmp_pkg::CMD_CLEAR,  8'h00, 7'd1,  1'b1, RES_ZERO}
  };

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [kmp_pkg::CMD_W-1:0]  in_command = kmp_pkg::CMD_CLEAR;
  logic [kmp_pkg::CHAR_W-1:0] in_char_value = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_match_here;
  logic                       out_found;
  logic [31:0]                out_match_end;
  logic [LEN_W-1:0]           out_matched_length;
  logic                       out_overflow;

  kmp_stream_matcher_unit #(
    .PATTERN_MAX(PAT_MAX),
    .INDEX_BITS (IDX_BITS)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_char_value     (in_char_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_match_here    (out_match_here),
    .out_found         (out_found),
    .out_match_end     (out_match_end),
    .out_matched_length(out_matched_length),
    .out_overflow      (out_overflow)
  );

  // matcher state as the bench tracks it
  logic [7:0]       pat_bytes  [PAT_MAX] = '{default: '0};
  logic [5:0]       fail_links [PAT_MAX] = '{default: '0};
  logic [LEN_W-1:0] pat_len        = '0;
  logic [5:0]       build_k        = '0;
  logic [LEN_W-1:0] match_pos      = '0;
  logic             seen_match     = 1'b0;
  logic [31:0]      text_pos       = '0;
  logic             dropped_append = 1'b0;

  match_result_t pending_results [$];
  int unsigned   beats_sent     = 0;
  int unsigned   error_count    = 0;
  int unsigned   tx_idle_pct    = 0;
  int unsigned   rx_stall_pct   = 0;
  int unsigned   long_hold_left = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // advance the tracked state by one beat and return the result it gives
  function automatic match_result_t kmp_step_result(kmp_pkg::kmp_cmd_t cmd,
                                                    logic [7:0] ch);
    match_result_t res;
    int unsigned   k;
    int unsigned   m;
    res = '0;
    case (cmd)
      kmp_pkg::CMD_CLEAR: begin
        pat_len        = '0;
        build_k        = '0;
        match_pos      = '0;
        seen_match     = 1'b0;
        text_pos       = '0;
        dropped_append = 1'b0;
      end
      kmp_pkg::CMD_APPEND: begin
        if (pat_len >= PAT_MAX) begin
          dropped_append = 1'b1;
        end else begin
          k = 0;
          if (pat_len != 0) begin
            k = build_k;
            while (k > 0 && pat_bytes[k] != ch) k = fail_links[k-1];
            if (pat_bytes[k] == ch) k++;
          end
          fail_links[pat_len] = k[5:0];
          build_k             = k[5:0];
          pat_bytes[pat_len]  = ch;
          pat_len             = pat_len + 1'b1;
        end
        res.found       = seen_match;
        res.matched_len = match_pos;
      end
      kmp_pkg::CMD_TEXT: begin
        res.match_end = text_pos;
        if (text_pos != '1) text_pos = text_pos + 1'b1;
        if (pat_len != 0) begin
          m = match_pos;
          while (m > 0 && pat_bytes[m] != ch) m = fail_links[m-1];
          if (pat_bytes[m] == ch) m++;
          res.matched_len = m[LEN_W-1:0];
          if (m >= pat_len) begin
            res.match_here = 1'b1;
            seen_match     = 1'b1;
            m              = fail_links[pat_len-1];
          end
          match_pos = m[LEN_W-1:0];
        end
        res.found = seen_match;
      end
      default: begin
        res.found  = seen_match;
        seen_match = 1'b0;
        match_pos  = '0;
        text_pos   = '0;
      end
    endcase
    res.overflow = dropped_append;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // offer one beat, wait for it to be taken, record what it should give
  task automatic send_beat(input kmp_pkg::kmp_cmd_t cmd, input logic [7:0] ch,
                           input bit typed = 1'b0,
                           input match_result_t typed_res = '0);
    match_result_t predicted;
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_char_value <= ch;
    do @(posedge clk); while (in_stall);
    predicted = kmp_step_result(cmd, ch);
    pending_results = {pending_results, (typed ? typed_res : predicted)};
    beats_sent++;
    // sender gap, drawn per cycle
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  // hold the input back until every pending result has arrived
  task automatic drain_results;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // one search: clear, a pattern from a small alphabet, text, mostly end of text
  task automatic run_search;
    logic [7:0]  alpha [3];
    int unsigned n_sym;
    int unsigned pat_n;
    int unsigned txt_n;
    int unsigned pick;
    for (int i = 0; i < 3; i++) alpha[i] = 8'($urandom_range(255));
    n_sym = $urandom_range(1, 3);
    // occasional noise burst of arbitrary beats
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(5, 15))
        send_beat(kmp_pkg::kmp_cmd_t'($urandom_range(3)), 8'($urandom_range(255)));
    end
    send_beat(kmp_pkg::CMD_CLEAR, 8'($urandom_range(255)));
    pick = $urandom_range(19);
    if (pick == 0)      pat_n = 0;
    else if (pick == 1) pat_n = $urandom_range(60, 70);
    else                pat_n = $urandom_range(1, 6);
    repeat (pat_n) send_beat(kmp_pkg::CMD_APPEND, alpha[$urandom_range(n_sym - 1)]);
    txt_n = $urandom_range(4, 30);
    repeat (txt_n) begin
      pick = $urandom_range(99);
      if (pick < 5)
        send_beat(kmp_pkg::CMD_TEXT, 8'($urandom_range(255)));
      else if (pick < 7)
        send_beat(kmp_pkg::CMD_APPEND, alpha[$urandom_range(n_sym - 1)]);
      else
        send_beat(kmp_pkg::CMD_TEXT, alpha[$urandom_range(n_sym - 1)]);
    end
    if ($urandom_range(9) != 0) send_beat(kmp_pkg::CMD_EOT, 8'($urandom_range(255)));
  endtask

  // receiver: long hold-off when asked, otherwise random stalls
  always @(posedge clk) begin
    if (long_hold_left != 0) begin
      out_stall      <= 1'b1;
      long_hold_left <= long_hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // result checking against the oldest pending beat
  always @(posedge clk) begin
    match_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        want = pending_results.pop_front();
        check_field("match_here", 32'(out_match_here), 32'(want.match_here));
        check_field("found", 32'(out_found), 32'(want.found));
        check_field("match_end", out_match_end, want.match_end);
        check_field("matched_length", 32'(out_matched_length), 32'(want.matched_len));
        check_field("overflow", 32'(out_overflow), 32'(want.overflow));
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[kmp_stream_matcher_unit] ERROR");
    $finish;
  end

  // stimulus
  initial begin
    int unsigned tx_pcts [4];
    int unsigned rx_pcts [4];
    int unsigned phase;
    int unsigned phase_end;
    int unsigned total_target;
    tx_pcts = '{0, 61, 0, 12};
    rx_pcts = '{0, 0, 61, 12};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < N_ROWS; r++) begin
      repeat (directed_rows[r].reps)
        send_beat(directed_rows[r].cmd, directed_rows[r].ch,
                  directed_rows[r].typed, directed_rows[r].want);
    end
    drain_results();

    // receiver holds off for a long stretch while the sender keeps offering
    long_hold_left <= 150;
    run_search();
    run_search();
    drain_results();

    // random searches, cycling through the idling phases
    total_target = beats_sent + RANDOM_BEATS;
    phase = 0;
    while (beats_sent < total_target) begin
      tx_idle_pct  = tx_pcts[phase];
      rx_stall_pct = rx_pcts[phase];
      phase_end    = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end) run_search();
      drain_results();
      phase = (phase + 1) % 4;
    end

    rx_stall_pct = 0;
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("[kmp_stream_matcher_unit] OK");
    end else begin
      $display("[kmp_stream_matcher_unit] ERROR");
    end
    $finish;
  end

endmodule
